[hdl/rde_pkg.sv]
// Shared types and constants for the radix digit emitter.
`default_nettype none

package rde_pkg;

	localparam int NUM_W          = 64;
	localparam int BASE_W         = 5;
	localparam int DIGIT_W        = 4;
	localparam int CHAR_W         = 8;
	localparam int RDE_MAX_DIGITS = 64;
	localparam int FIXED_DIGITS   = 8;

	localparam logic [BASE_W-1:0] BASE_MIN  = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX  = 5'd16;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;

	localparam logic OP_MINIMAL = 1'b0;
	localparam logic OP_FIXED   = 1'b1;

	typedef struct packed {
		logic [NUM_W-1:0]  number;
		logic [BASE_W-1:0] base;
		logic              op;
	} rde_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
		logic              error;
	} rde_rsp_t;

endpackage

`default_nettype wire

[hdl/rde_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rde_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/rde_divider.sv]
// Iterative divider of a 64-bit value by a small base, eight quotient bits per cycle.
`default_nettype none

module rde_divider (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [rde_pkg::NUM_W-1:0]    dividend,
	input  wire logic [rde_pkg::BASE_W-1:0]   base,
	output      logic                         done,
	output      logic [rde_pkg::NUM_W-1:0]    quotient,
	output      logic [rde_pkg::DIGIT_W-1:0]  remainder
);

	import rde_pkg::*;

	localparam int BITS_PER_CYCLE = 8;
	localparam int STEPS          = NUM_W / BITS_PER_CYCLE;
	localparam int STEP_W         = $clog2(STEPS);

	logic [NUM_W-1:0]  acc_q;
	logic [BASE_W-1:0] rem_q;
	logic [BASE_W-1:0] base_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [NUM_W-1:0]  acc_n;
	logic [BASE_W-1:0] rem_n;
	logic              top_bit;

	// Restoring long division: the dividend shifts out at the top while the
	// quotient bits shift in at the bottom of the same register.
	always_comb begin
		acc_n = acc_q;
		rem_n = rem_q;
		top_bit = 1'b0;
		for (int i = 0; i < BITS_PER_CYCLE; i++) begin
			top_bit = acc_n[NUM_W-1];
			acc_n   = {acc_n[NUM_W-2:0], 1'b0};
			rem_n   = {rem_n[BASE_W-2:0], top_bit};
			if (rem_n >= base_q) begin
				rem_n    = rem_n - base_q;
				acc_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= dividend;
			rem_q  <= '0;
			base_q <= base;
		end else if (busy_q) begin
			acc_q <= acc_n;
			rem_q <= rem_n;
		end
	end

	assign done      = done_q;
	assign quotient  = acc_q;
	assign remainder = rem_q[DIGIT_W-1:0];

endmodule

`default_nettype wire

[hdl/radix_digit_emitter.sv]
// Top level of the radix digit emitter: converts a 64-bit number to digit characters.
// Each digit is one run of the divider; its remainder is then stored in the digit memory.
// Once all digits of an item are stored, results follow at one result per cycle while the
// consumer takes them; a new item is taken after the last digit moves into the output
// register. An invalid base answers with a single flagged result.
// Reset clears all control state; the digit memory is not cleared and needs no sweep.
`default_nettype none

module radix_digit_emitter #(
	parameter int MAX_DIGITS = rde_pkg::RDE_MAX_DIGITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output      logic              req_ready,
	input  wire rde_pkg::rde_req_t req,
	output      logic              rsp_valid,
	input  wire logic              rsp_ready,
	output      rde_pkg::rde_rsp_t rsp
);

	import rde_pkg::*;

	// Digit memory addressing and the digit counters follow from MAX_DIGITS.
	localparam int AW   = $clog2(MAX_DIGITS);
	localparam int CW   = $clog2(MAX_DIGITS + 1);
	localparam int WANT = (FIXED_DIGITS > MAX_DIGITS) ? MAX_DIGITS : FIXED_DIGITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;
	localparam logic [1:0] S_ERR  = 2'd3;

	logic [1:0]   state_q;
	logic         fixed_q;
	logic [BASE_W-1:0] base_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] remain_q;
	logic          pend_q;
	logic          pend_last_q;
	logic          rsp_valid_q;
	rde_rsp_t      rsp_q;

	logic               accept;
	logic               base_ok;
	logic               div_start;
	logic [NUM_W-1:0]   div_dividend;
	logic [BASE_W-1:0]  div_base;
	logic               div_done;
	logic [NUM_W-1:0]   div_quot;
	logic [DIGIT_W-1:0] div_rem;
	logic [CW-1:0]      count_inc;
	logic [CW-1:0]      remain_dec;
	logic               more;
	logic               store;
	logic               out_free;
	logic               load;
	logic               issue;
	logic               err_load;
	logic [DIGIT_W-1:0] ram_rdata;

	// The block converts one item at a time; it takes a new item only from idle,
	// while the previous item's final result may still wait in the output register.
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign base_ok   = (req.base >= BASE_MIN) && (req.base <= BASE_MAX);

	// A digit is written each time the divider finishes. Minimal mode stops when
	// the quotient reaches zero or the memory is full; fixed mode counts digits.
	assign count_inc  = count_q + CW'(1);
	assign store      = (state_q == S_DIV) && div_done;
	assign more       = fixed_q ? (count_inc < CW'(WANT))
	                            : ((div_quot != '0) && (count_inc < CW'(MAX_DIGITS)));
	assign div_start  = (accept && base_ok) || (store && more);
	assign div_dividend = (state_q == S_IDLE) ? req.number : div_quot;
	// The input bus may already carry the next item, so later digits use the
	// base captured at acceptance.
	assign div_base     = (state_q == S_IDLE) ? req.base : base_q;

	// Emission reads digits most significant first. The memory's read register
	// holds its data until the next read, so a read may be issued in the same
	// cycle that the previous digit moves into the output register.
	assign remain_dec = remain_q - CW'(1);
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign load       = (state_q == S_EMIT) && pend_q && out_free;
	assign issue      = (state_q == S_EMIT) && (remain_q != '0) && (!pend_q || load);
	assign err_load   = (state_q == S_ERR) && out_free;

	rde_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.base      (div_base),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	rde_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (store),
		.waddr (count_q[AW-1:0]),
		.wdata (div_rem),
		.re    (issue),
		.raddr (remain_dec[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fixed_q     <= OP_MINIMAL;
			base_q      <= '0;
			count_q     <= '0;
			remain_q    <= '0;
			pend_q      <= 1'b0;
			pend_last_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (base_ok) begin
							state_q <= S_DIV;
							fixed_q <= req.op;
							base_q  <= req.base;
							count_q <= '0;
						end else begin
							state_q <= S_ERR;
						end
					end
				end
				S_DIV: begin
					if (store) begin
						count_q <= count_inc;
						if (!more) begin
							state_q  <= S_EMIT;
							remain_q <= count_inc;
							pend_q   <= 1'b0;
						end
					end
				end
				S_EMIT: begin
					if (issue) begin
						remain_q    <= remain_dec;
						pend_last_q <= (remain_q == CW'(1));
						pend_q      <= 1'b1;
					end else if (load) begin
						pend_q <= 1'b0;
					end
					if ((remain_q == '0) && (!pend_q || load)) begin
						state_q <= S_IDLE;
					end
				end
				S_ERR: begin
					if (err_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (err_load || load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: an invalid base gives a single flagged item with a zero
	// character; digits above nine are not mapped to letters.
	always_ff @(posedge clk) begin
		if (err_load) begin
			rsp_q.character <= '0;
			rsp_q.last      <= 1'b1;
			rsp_q.error     <= 1'b1;
		end else if (load) begin
			rsp_q.character <= CHAR_ZERO + CHAR_W'(ram_rdata);
			rsp_q.last      <= pend_last_q;
			rsp_q.error     <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
